/* design/stop_and_wait_datagram_receiver_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the stop-and-wait datagram receiver
// Shared property wrappers clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef STOP_AND_WAIT_DATAGRAM_RECEIVER_UNIT_MACROS_SVH
`define STOP_AND_WAIT_DATAGRAM_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication
`define SWDR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SWDR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/swdr_pkg.sv */
// ---------------------------------------------------------------------------
// swdr_pkg
// Types, reply codes and register indexes of the datagram receiver.
// ---------------------------------------------------------------------------
package swdr_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TYPE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_TYPE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAIN_PROTO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELIABLE_PROTO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 3'd4;

  // Reply kinds
  localparam logic [2:0] KIND_ACCEPT   = 3'd0;
  localparam logic [2:0] KIND_REFUSE   = 3'd1;
  localparam logic [2:0] KIND_ACK      = 3'd2;
  localparam logic [2:0] KIND_REJECT   = 3'd3;
  localparam logic [2:0] KIND_RECEIVED = 3'd4;

  // Result queue depth (largest burst of replies per word)
  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  typedef struct packed {
    logic        action;
    logic [7:0]  packet_type;
    logic [63:0] conn_id;
    logic [7:0]  protocol;
    logic [63:0] total_bytes;
    logic [63:0] seq_num;
    logic [31:0] declared_len;
    logic [15:0] payload_len;
    logic        header_complete;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  reply_kind;
    logic [63:0] reply_session;
    logic [63:0] reply_package;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       fire;
    logic [1:0] count;
    logic       connected;
  } core_status_t;

  typedef struct packed {
    logic [1:0] count;
    logic [1:0] free_slots;
  } queue_status_t;

  function automatic result_t make_result(logic [2:0] kind, logic [63:0] sess,
                                          logic [63:0] pkg);
    result_t r;
    r.reply_kind    = kind;
    r.reply_session = sess;
    r.reply_package = pkg;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

/* design/swdr_in_reg.sv */
// ---------------------------------------------------------------------------
// swdr_in_reg
// Input register: captures one header word and holds it until processed.
// ---------------------------------------------------------------------------
module swdr_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              action,
  input  logic [7:0]        packet_type,
  input  logic [63:0]       conn_id,
  input  logic [7:0]        protocol,
  input  logic [63:0]       total_bytes,
  input  logic [63:0]       seq_num,
  input  logic [31:0]       declared_len,
  input  logic [15:0]       payload_len,
  input  logic              header_complete,
  input  logic              take,
  output logic              item_valid,
  output swdr_pkg::in_item_t item
);
  import swdr_pkg::*;

  logic load;

  // Stall only while a held word is not consumed this cycle
  assign in_stall = item_valid && !take;
  assign load     = in_valid && !in_stall;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load) begin
      item.action          <= action;
      item.packet_type     <= packet_type;
      item.conn_id         <= conn_id;
      item.protocol        <= protocol;
      item.total_bytes     <= total_bytes;
      item.seq_num         <= seq_num;
      item.declared_len    <= declared_len;
      item.payload_len     <= payload_len;
      item.header_complete <= header_complete;
    end
  end

endmodule

/* design/swdr_core.sv */
// ---------------------------------------------------------------------------
// swdr_core
// Session state, configuration registers and reply decision for one word.
// ---------------------------------------------------------------------------
module swdr_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [swdr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swdr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              item_valid,
  input  swdr_pkg::in_item_t                item,
  input  logic [1:0]                        free_slots,
  output swdr_pkg::core_status_t            status,
  output swdr_pkg::result_t                 push0,
  output swdr_pkg::result_t                 push1
);
  import swdr_pkg::*;

  // Configuration registers
  logic [7:0] connect_type_code;
  logic [7:0] data_type_code;
  logic [7:0] plain_protocol_code;
  logic [7:0] reliable_protocol_code;
  logic [7:0] retry_limit;

  // Session state; remaining replaces expected minus received bytes,
  // prev_package holds expected_package minus one
  logic        connected, connected_next;
  logic        reliable_mode, reliable_mode_next;
  logic [63:0] current_session, current_session_next;
  logic [63:0] remaining, remaining_next;
  logic [63:0] expected_package, expected_package_next;
  logic [63:0] prev_package, prev_package_next;
  logic [7:0]  retry_count, retry_count_next;
  logic        awaiting_first_data, awaiting_first_data_next;

  logic        fire;
  logic [1:0]  cnt;
  result_t     res0, res1;

  logic        is_plain, is_rel, connect_ok;
  logic        retx_drop;
  result_t     retx_reply;
  logic [63:0] pkg_inc;
  logic [31:0] plen_ext;
  logic [63:0] dlen_ext;
  result_t     final_reply;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      connect_type_code      <= 8'd1;
      data_type_code         <= 8'd4;
      plain_protocol_code    <= 8'd2;
      reliable_protocol_code <= 8'd3;
      retry_limit            <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONNECT_TYPE:   connect_type_code      <= cfg_data;
        CFG_DATA_TYPE:      data_type_code         <= cfg_data;
        CFG_PLAIN_PROTO:    plain_protocol_code    <= cfg_data;
        CFG_RELIABLE_PROTO: reliable_protocol_code <= cfg_data;
        CFG_RETRY_LIMIT:    retry_limit            <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shared comparisons
  assign is_plain   = item.protocol == plain_protocol_code;
  assign is_rel     = item.protocol == reliable_protocol_code;
  assign connect_ok = item.header_complete && (item.packet_type == connect_type_code)
                      && (is_plain || is_rel);
  assign retx_drop  = retry_count >= retry_limit;
  assign retx_reply = awaiting_first_data
                      ? make_result(KIND_ACCEPT, current_session, 64'd0)
                      : make_result(KIND_ACK, current_session, prev_package);
  assign pkg_inc    = expected_package + 64'd1;
  assign plen_ext   = {16'd0, item.payload_len};
  assign dlen_ext   = {32'd0, item.declared_len};
  assign final_reply = (dlen_ext == remaining)
                       ? make_result(KIND_RECEIVED, current_session, 64'd0)
                       : make_result(KIND_REJECT, current_session, pkg_inc);

  // Decide replies and next state
  always_comb begin
    cnt  = 2'd0;
    res0 = make_result(KIND_ACCEPT, 64'd0, 64'd0);
    res1 = make_result(KIND_ACCEPT, 64'd0, 64'd0);
    connected_next           = connected;
    reliable_mode_next       = reliable_mode;
    current_session_next     = current_session;
    remaining_next           = remaining;
    expected_package_next    = expected_package;
    prev_package_next        = prev_package;
    retry_count_next         = retry_count;
    awaiting_first_data_next = awaiting_first_data;

    if (!connected) begin
      if (!item.action) begin
        if (!connect_ok) begin
          res0 = make_result(KIND_REFUSE, item.conn_id, 64'd0);
          cnt  = 2'd1;
        end else begin
          res0 = make_result(KIND_ACCEPT, item.conn_id, 64'd0);
          current_session_next     = item.conn_id;
          remaining_next           = item.total_bytes;
          expected_package_next    = 64'd0;
          prev_package_next        = '1;
          retry_count_next         = 8'd0;
          awaiting_first_data_next = 1'b1;
          reliable_mode_next       = !is_plain;
          if (item.total_bytes == 64'd0) begin
            res1 = make_result(KIND_RECEIVED, item.conn_id, 64'd0);
            cnt  = 2'd2;
          end else begin
            connected_next = 1'b1;
            cnt            = 2'd1;
          end
        end
      end
    end else if (item.action) begin
      if (!reliable_mode || retx_drop) begin
        connected_next = 1'b0;
      end else begin
        retry_count_next = retry_count + 8'd1;
        res0 = retx_reply;
        cnt  = 2'd1;
      end
    end else if (!item.header_complete) begin
      res0 = make_result(KIND_REJECT, current_session, expected_package);
      cnt  = 2'd1;
      connected_next = 1'b0;
    end else if (item.conn_id != current_session) begin
      res0 = make_result(KIND_REFUSE, current_session, 64'd0);
      cnt  = 2'd1;
    end else if (item.packet_type != data_type_code) begin
      res0 = make_result(KIND_REJECT, current_session, item.seq_num);
      cnt  = 2'd1;
      connected_next = 1'b0;
    end else if (item.seq_num != expected_package) begin
      if (reliable_mode && (item.seq_num < expected_package)) begin
        if (retx_drop) begin
          connected_next = 1'b0;
        end else begin
          retry_count_next = retry_count + 8'd1;
          res0 = retx_reply;
          cnt  = 2'd1;
        end
      end else begin
        res0 = make_result(KIND_REJECT, current_session, item.seq_num);
        cnt  = 2'd1;
        connected_next = 1'b0;
      end
    end else if (plen_ext != item.declared_len) begin
      res0 = make_result(KIND_REJECT, current_session, item.seq_num);
      cnt  = 2'd1;
      connected_next = 1'b0;
    end else begin
      // Good data word: count it, ack in reliable mode, close on completion
      awaiting_first_data_next = 1'b0;
      expected_package_next    = pkg_inc;
      prev_package_next        = expected_package;
      if (reliable_mode) begin
        res0 = make_result(KIND_ACK, current_session, expected_package);
        cnt  = 2'd1;
      end
      if (dlen_ext < remaining) begin
        remaining_next = remaining - dlen_ext;
      end else begin
        remaining_next = 64'd0;
        connected_next = 1'b0;
        if (reliable_mode) begin
          res1 = final_reply;
          cnt  = 2'd2;
        end else begin
          res0 = final_reply;
          cnt  = 2'd1;
        end
      end
    end

    // Mark the final reply of this word
    if (cnt == 2'd1) begin
      res0.last = 1'b1;
    end else if (cnt == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  // Commit only when the result queue has room for every reply
  assign fire = item_valid && (cnt <= free_slots);

  always_ff @(posedge clk) begin
    if (rst) begin
      connected           <= 1'b0;
      reliable_mode       <= 1'b0;
      current_session     <= 64'd0;
      remaining           <= 64'd0;
      expected_package    <= 64'd0;
      prev_package        <= '1;
      retry_count         <= 8'd0;
      awaiting_first_data <= 1'b1;
    end else if (fire) begin
      connected           <= connected_next;
      reliable_mode       <= reliable_mode_next;
      current_session     <= current_session_next;
      remaining           <= remaining_next;
      expected_package    <= expected_package_next;
      prev_package        <= prev_package_next;
      retry_count         <= retry_count_next;
      awaiting_first_data <= awaiting_first_data_next;
    end
  end

  assign status.fire      = fire;
  assign status.count     = cnt;
  assign status.connected = connected;
  assign push0            = res0;
  assign push1            = res1;

endmodule

/* design/swdr_out_queue.sv */
// ---------------------------------------------------------------------------
// swdr_out_queue
// Two-entry result queue: takes up to two replies per cycle, sends one.
// ---------------------------------------------------------------------------
module swdr_out_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  swdr_pkg::core_status_t  core_status,
  input  swdr_pkg::result_t       push0,
  input  swdr_pkg::result_t       push1,
  input  logic                    out_stall,
  output logic                    out_valid,
  output swdr_pkg::result_t       head,
  output swdr_pkg::queue_status_t status
);
  import swdr_pkg::*;

  result_t    slots [2];
  logic       wp, rp;
  logic [1:0] count, count_next;
  logic [1:0] push_n;
  logic       pop;

  assign out_valid = count != 2'd0;
  assign pop       = out_valid && !out_stall;
  assign push_n    = core_status.fire ? core_status.count : 2'd0;
  assign count_next = count + push_n - {1'b0, pop};
  assign head      = slots[rp];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      count <= count_next;
      wp    <= wp ^ push_n[0];
      rp    <= rp ^ pop;
    end
  end

  // Write replies in order
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      slots[wp] <= push0;
    end
    if (push_n == 2'd2) begin
      slots[~wp] <= push1;
    end
  end

  assign status.count      = count;
  assign status.free_slots = QUEUE_DEPTH - count + {1'b0, pop};

endmodule

/* design/stop_and_wait_datagram_receiver_unit.sv */
// ---------------------------------------------------------------------------
// stop_and_wait_datagram_receiver_unit
// Receiver side of a stop-and-wait connect/data/ack protocol.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one parsed header or a timeout
// per word. Output channel (out_valid/out_stall) carries reply words; a word
// that causes two replies (accept then received, ack then received or
// reject) gives them on consecutive output words, the second flagged last.
// A header is registered in the input register, decided by the core and,
// once the result queue has room for all its replies, written to the queue,
// whose head drives the reply outputs. Throughput: one input word per cycle
// while out_stall is low and every word gives at most one reply; a two-reply
// word leaves the two-entry result queue one reply per output word, which
// sets the sustained rate. Configuration: cfg_we, cfg_index, cfg_data write
// the five 8-bit registers; indexes beyond them are ignored. The user must
// write them only while the block is idle; the block does not enforce it.
// Reset (rst, synchronous) restores the register defaults, drops any
// session and empties both the input register and the result queue.
// When out_stall is high the queue fills; once it cannot hold the replies
// of the held header, in_stall rises until the queue drains.
// ---------------------------------------------------------------------------
`include "stop_and_wait_datagram_receiver_unit_macros.svh"

module stop_and_wait_datagram_receiver_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [swdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swdr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            action,
  input  logic [7:0]                      packet_type,
  input  logic [63:0]                     conn_id,
  input  logic [7:0]                      protocol,
  input  logic [63:0]                     total_bytes,
  input  logic [63:0]                     seq_num,
  input  logic [31:0]                     declared_len,
  input  logic [15:0]                     payload_len,
  input  logic                            header_complete,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      reply_kind,
  output logic [63:0]                     reply_session,
  output logic [63:0]                     reply_package,
  output logic                            last
);
  import swdr_pkg::*;

  logic          item_valid;
  in_item_t      item;
  core_status_t  core_status;
  queue_status_t queue_status;
  result_t       push0, push1, head;

  // Header register
  swdr_in_reg u_in_reg (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .packet_type     (packet_type),
    .conn_id         (conn_id),
    .protocol        (protocol),
    .total_bytes     (total_bytes),
    .seq_num         (seq_num),
    .declared_len    (declared_len),
    .payload_len     (payload_len),
    .header_complete (header_complete),
    .take            (core_status.fire),
    .item_valid      (item_valid),
    .item            (item)
  );

  // Session logic
  swdr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .free_slots (queue_status.free_slots),
    .status     (core_status),
    .push0      (push0),
    .push1      (push1)
  );

  // Reply queue
  swdr_out_queue u_out_queue (
    .clk         (clk),
    .rst         (rst),
    .core_status (core_status),
    .push0       (push0),
    .push1       (push1),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .head        (head),
    .status      (queue_status)
  );

  assign reply_kind    = head.reply_kind;
  assign reply_session = head.reply_session;
  assign reply_package = head.reply_package;
  assign last          = head.last;

  // Checks
  `SWDR_ASSERT_NXT(a_pair_shows, core_status.fire && (core_status.count == 2'd2),
    out_valid && (queue_status.count != 2'd0), "two-reply word left the queue empty")
  `SWDR_ASSERT_IMP(a_idle_timeout_silent,
    core_status.fire && !core_status.connected && item.action,
    core_status.count == 2'd0, "idle timeout produced a reply")
  `SWDR_ASSERT_IMP(a_fire_fits, core_status.fire,
    core_status.count <= queue_status.free_slots, "reply queue overrun")

endmodule
